>>> rtl/core/lism_pkg.sv
// Shared types and constants for the loop interval statistics monitor.
// Used by lism_ctrl, lism_dp and the top level; depends on nothing else.
`default_nettype none

package lism_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_MEAS_MODE     = 1'b0;
  localparam logic CFG_PERIOD_LENGTH = 1'b1;

  // Measurement modes
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_MIN = 2'd1;
  localparam logic [1:0] MODE_MAX = 2'd2;
  localparam logic [1:0] MODE_AVG = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_MIN = 2'd0;
  localparam logic [1:0] KIND_MAX = 2'd1;
  localparam logic [1:0] KIND_AVG = 2'd2;

  // Input item function
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] PERIOD_RESET = 32'd1_000_000;
  localparam logic [4:0]  DIV_LAST     = 5'd31;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic restart;
    logic update;
    logic div_start;
    logic emit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_restart;
    logic report_due;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/lism_ctrl.sv
// Controller state machine of the interval statistics monitor.
// Sequences one transaction at a time and owns the result valid flag; uses lism_pkg.
`default_nettype none

module lism_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        meas_mode,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire lism_pkg::dp_stat_t stat,
  output lism_pkg::dp_cmd_t      cmd
);
  import lism_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DECIDE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   in_accept;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load_in   = in_accept;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.is_restart) begin
          cmd.restart = 1'b1;
          state_next  = ST_IDLE;
        end else if (meas_mode == MODE_OFF) begin
          state_next = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.report_due) begin
          state_next = ST_IDLE;
        end else if (meas_mode == MODE_AVG) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // A result is loaded only when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transaction");

  // One item at a time: no transaction directly after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // The divider is started only for an average report
  a_div_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (meas_mode == MODE_AVG && stat.report_due))
    else $error("divider started outside an average report");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lism_dp.sv
// Datapath of the interval statistics monitor: statistics registers,
// period check, 32-step restoring divider and result register. Uses lism_pkg.
`default_nettype none

module lism_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [1:0]           meas_mode,
  input  wire logic [31:0]          period_length,
  input  wire logic                 in_func,
  input  wire logic [31:0]          in_now,
  input  wire lism_pkg::dp_cmd_t    cmd,
  output lism_pkg::dp_stat_t        stat,
  output logic [31:0]               stat_value,
  output logic [1:0]                stat_kind
);
  import lism_pkg::*;

  logic        item_func;
  logic [31:0] item_now;
  logic [31:0] last_tick_time;
  logic [31:0] period_start;
  logic [31:0] tick_count;
  logic [31:0] interval_sum;
  logic [31:0] min_interval;
  logic [31:0] max_interval;
  logic        report_due;

  logic [31:0] div_q;
  logic [31:0] div_rem;
  logic [31:0] div_den;
  logic [4:0]  div_cnt;
  logic        div_busy;

  logic [31:0] gap;
  logic [31:0] elapsed;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [32:0] rem_sub;
  logic [31:0] report_value;

  assign gap     = item_now - last_tick_time;
  assign elapsed = item_now - period_start;

  // One restoring division step
  assign rem_sh  = {div_rem, div_q[31]};
  assign rem_ge  = (rem_sh >= {1'b0, div_den});
  assign rem_sub = rem_sh - {1'b0, div_den};

  // Statistic selected by the mode
  always_comb begin
    case (meas_mode)
      MODE_MIN: report_value = min_interval;
      MODE_MAX: report_value = max_interval;
      default:  report_value = div_q;
    endcase
  end

  assign stat.is_restart = (item_func == FUNC_RESTART);
  assign stat.report_due = report_due;
  assign stat.div_done   = div_busy && (div_cnt == DIV_LAST);

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_func <= in_func;
      item_now  <= in_now;
    end
  end

  // Statistics and period bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick_time <= '0;
      period_start   <= '0;
      tick_count     <= '0;
      interval_sum   <= '0;
      min_interval   <= ALL_ONES;
      max_interval   <= '0;
      report_due     <= 1'b0;
    end else if (cmd.restart || cmd.emit) begin
      period_start <= item_now;
      tick_count   <= '0;
      interval_sum <= '0;
      min_interval <= ALL_ONES;
      max_interval <= '0;
    end else if (cmd.update) begin
      last_tick_time <= item_now;
      tick_count     <= tick_count + 32'd1;
      interval_sum   <= interval_sum + gap;
      if (gap < min_interval) min_interval <= gap;
      if (gap > max_interval) max_interval <= gap;
      report_due <= (elapsed >= period_length);
    end
  end

  // Serial divider: sum / count, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == DIV_LAST) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= interval_sum;
      div_den <= tick_count;
      div_rem <= '0;
    end else if (div_busy) begin
      div_q   <= {div_q[30:0], rem_ge};
      div_rem <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stat_value <= report_value;
      stat_kind  <= meas_mode - 2'd1;
    end
  end

`ifndef ASSERT_OFF
  // With at least one tick in the period the minimum never exceeds the maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (tick_count != 32'd0) |-> (min_interval <= max_interval))
    else $error("minimum above maximum");

  // The divider counts one step per cycle while busy
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (div_busy && !stat.div_done && !cmd.div_start) |=>
      (div_cnt == 5'($past(div_cnt) + 5'd1)))
    else $error("divider step counter slipped");

  // A fresh period has empty statistics
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.restart || cmd.emit) |=> (tick_count == 32'd0 && max_interval == 32'd0))
    else $error("statistics not cleared at period start");
`endif

endmodule

`default_nettype wire

>>> rtl/core/loop_interval_stats_monitor.sv
// Loop interval statistics monitor: top level, configuration registers and
// the controller/datapath pair. Depends on lism_pkg, lism_ctrl and lism_dp.
//
// Each tick (s_tuser = 0, timestamp in s_tdata) outside mode off measures
// the interval since the previous tick and keeps the minimum, maximum, sum
// and count; once the period length has elapsed since the period start, one
// result leaves on the master side (m_tdata = value, m_tuser = kind) and a
// new period begins. A restart item (s_tuser = 1) clears the statistics and
// restarts the period at its timestamp. Items are taken one at a time; an
// average report first runs the 32-step serial divider. The result register
// frees the input side, so the next item is accepted while a result still
// waits; only a second report waits for the first to be taken. Configuration
// is written through cfg_we/cfg_index/cfg_wdata by the user only while idle;
// the block itself does not enforce this.
`default_nettype none

module loop_interval_stats_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] now_us
  input  wire logic        s_tuser,   // [0] func
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] stat_value
  output logic [1:0]       m_tuser    // [1:0] stat_kind
);
  import lism_pkg::*;

  logic [1:0]  meas_mode;
  logic [31:0] period_length;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_mode     <= MODE_OFF;
      period_length <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAS_MODE:     meas_mode     <= cfg_wdata[1:0];
        CFG_PERIOD_LENGTH: period_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lism_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .meas_mode (meas_mode),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lism_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .meas_mode     (meas_mode),
    .period_length (period_length),
    .in_func       (s_tuser),
    .in_now        (s_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .stat_value    (m_tdata),
    .stat_kind     (m_tuser)
  );

endmodule

`default_nettype wire
